// ===== rtl/core/gsp_pkg.sv =====
package gsp_pkg;

   localparam int GRID_N    = 128;
   localparam int STRIDE    = GRID_N + 2;
   localparam int CELLS     = STRIDE * STRIDE;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int IDX_W     = $clog2(STRIDE);
   localparam int FIELD_W   = 8;
   localparam int DATA_W    = 32;
   localparam int ACC_W     = DATA_W + 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] OP_WRITE_U = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_READ_U  = 2'd2;
   localparam logic [1:0] OP_SWEEP   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SQUARED  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERIOR_SIZE = 1'b1;

   localparam logic [DATA_W-1:0]  STEP_SQUARED_RESET  = 32'd262144;
   localparam logic [FIELD_W-1:0] INTERIOR_SIZE_RESET = 8'd128;

   localparam logic [1:0] ACC_HOLD  = 2'd0;
   localparam logic [1:0] ACC_LOAD  = 2'd1;
   localparam logic [1:0] ACC_ADD_U = 2'd2;
   localparam logic [1:0] ACC_ADD_P = 2'd3;

   typedef struct packed {
      logic [1:0] acc_op;
      logic       prod_en;
      logic       old_en;
      logic       nv_en;
      logic       best_clr;
      logic       best_upd;
   } dp_ctrl_type;

endpackage

// ===== rtl/core/gsp_ram.sv =====
module gsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gsp_dpath.sv =====
module gsp_dpath (
   input  logic                             clock,
   input  gsp_pkg::dp_ctrl_type             ctrl,
   input  logic [gsp_pkg::DATA_W-1:0]       step_squared,
   input  logic [gsp_pkg::DATA_W-1:0]       u_rdata,
   input  logic [gsp_pkg::DATA_W-1:0]       b_rdata,
   output logic [gsp_pkg::DATA_W-1:0]       new_value,
   output logic [gsp_pkg::DATA_W-1:0]       best_change
);

   import gsp_pkg::*;

   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [2*DATA_W:0]    prod_full;
   logic [DATA_W-1:0]           prod_ff;
   logic [DATA_W-1:0]           old_ff;
   logic [DATA_W-1:0]           nv_ff;
   logic [DATA_W-1:0]           best_ff, best_in;
   logic signed [ACC_W-1:0]     u_ext, p_ext;
   logic signed [ACC_W-1:0]     rnd_sum, rnd_shift;
   logic [ACC_W-DATA_W:0]       rnd_hi;
   logic signed [DATA_W:0]      diff;
   logic [DATA_W:0]             diff_neg;
   logic [DATA_W-1:0]           mag;

   assign prod_full = $signed(b_rdata) * $signed({1'b0, step_squared});
   assign u_ext = {{(ACC_W-DATA_W){u_rdata[DATA_W-1]}}, u_rdata};
   assign p_ext = {{(ACC_W-DATA_W){prod_ff[DATA_W-1]}}, prod_ff};

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD:  acc_in = u_ext;
         ACC_ADD_U: acc_in = acc_ff + u_ext;
         ACC_ADD_P: acc_in = acc_ff + p_ext;
         default:   acc_in = acc_ff;
      endcase
   end

   // The stencil value is rounded half up, then saturated to the signed word.
   assign rnd_sum   = acc_ff + ACC_W'(2);
   assign rnd_shift = rnd_sum >>> 2;
   assign rnd_hi    = rnd_shift[ACC_W-1:DATA_W-1];

   always_comb begin
      if ((&rnd_hi) || !(|rnd_hi)) begin
         new_value = rnd_shift[DATA_W-1:0];
      end else if (rnd_shift[ACC_W-1]) begin
         new_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         new_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign diff     = $signed({old_ff[DATA_W-1], old_ff}) - $signed({nv_ff[DATA_W-1], nv_ff});
   assign diff_neg = -diff;
   assign mag      = diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];

   always_comb begin
      best_in = best_ff;
      if (ctrl.best_clr) begin
         best_in = '0;
      end else if (ctrl.best_upd && (mag > best_ff)) begin
         best_in = mag;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      best_ff <= best_in;
      if (ctrl.prod_en) begin
         prod_ff <= prod_full[2*DATA_W-1:DATA_W];
      end
      if (ctrl.old_en) begin
         old_ff <= u_rdata;
      end
      if (ctrl.nv_en) begin
         nv_ff <= new_value;
      end
   end

   assign best_change = best_ff[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : best_ff;

endmodule

// ===== rtl/core/gauss_seidel_poisson_sweep_core.sv =====
// Gauss-Seidel sweep engine for a five-point Poisson stencil on a bordered grid.
// Requests enter on the req_ channel (valid/ready) and each one returns exactly
// one response on the rsp_ channel. The csr_ channel writes the step_squared and
// interior_size registers and is always ready; write it only while no request
// is in flight.
// Each swept cell is worked in the phases up, down, left, right, center,
// product and write, because all five reads go through the single read port
// of the solution memory and share one accumulator. One request is in flight
// at a time; the next is accepted in the cycle after the previous response is
// loaded.
// After reset the solution memory is cleared one cell per cycle, all 16900
// cells; no request is accepted until it finishes.
// The response sits in an output register; if the receiver stalls, the core
// holds the finished response and waits before returning to idle.
module gauss_seidel_poisson_sweep_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic [gsp_pkg::FIELD_W-1:0]         req_row,
   input  logic [gsp_pkg::FIELD_W-1:0]         req_col,
   input  logic [gsp_pkg::FIELD_W-1:0]         req_last_row,
   input  logic signed [gsp_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gsp_pkg::DATA_W-1:0]   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gsp_pkg::DATA_W-1:0]          csr_wdata
);

   import gsp_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ACCESS = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_SWEEP  = 3'd4;
   localparam logic [2:0] S_SFIN   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam logic [2:0] PH_UP     = 3'd0;
   localparam logic [2:0] PH_DOWN   = 3'd1;
   localparam logic [2:0] PH_LEFT   = 3'd2;
   localparam logic [2:0] PH_RIGHT  = 3'd3;
   localparam logic [2:0] PH_CENTER = 3'd4;
   localparam logic [2:0] PH_PROD   = 3'd5;
   localparam logic [2:0] PH_WRITE  = 3'd6;

   localparam logic [ADDR_W-1:0] STRIDE_A = ADDR_W'(STRIDE);
   localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ONE_A    = ADDR_W'(1);
   localparam logic [IDX_W-1:0]  ONE_I    = IDX_W'(1);

   logic [2:0]          state_ff, state_in;
   logic [2:0]          phase_ff, phase_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0]   step_squared_ff;
   logic [FIELD_W-1:0]  interior_size_ff;

   logic [1:0]          op_ff, op_in;
   logic [FIELD_W-1:0]  row_req_ff, row_req_in;
   logic [FIELD_W-1:0]  col_req_ff, col_req_in;
   logic [FIELD_W-1:0]  last_req_ff, last_req_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic                inside_ff, inside_in;
   logic [DATA_W-1:0]   result_ff, result_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic [IDX_W-1:0]    col_ff, col_in;
   logic [IDX_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    last_ff, last_in;
   logic [ADDR_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0]   skip_ff, skip_in;

   logic                u_wr_en;
   logic [ADDR_W-1:0]   u_wr_addr;
   logic [DATA_W-1:0]   u_wr_data;
   logic [ADDR_W-1:0]   u_rd_addr;
   logic [DATA_W-1:0]   u_rdata;
   logic                b_wr_en;
   logic [DATA_W-1:0]   b_rdata;
   logic [ADDR_W-1:0]   acc_addr;
   logic                acc_inside;
   logic [DATA_W-1:0]   new_value;
   logic [DATA_W-1:0]   best_change;
   dp_ctrl_type         ctrl;

   int n_i, first_i, last_i;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign acc_inside = (int'(row_req_ff) <= GRID_N + 1) && (int'(col_req_ff) <= GRID_N + 1);
   assign acc_addr   = ADDR_W'(int'(row_req_ff) * STRIDE + int'(col_req_ff));

   always_comb begin
      n_i = int'(interior_size_ff);
      if (n_i < 2) begin
         n_i = 2;
      end else if (n_i > GRID_N) begin
         n_i = GRID_N;
      end
      first_i = int'(row_req_ff);
      if (first_i < 1) begin
         first_i = 1;
      end else if (first_i > n_i) begin
         first_i = n_i;
      end
      last_i = int'(last_req_ff);
      if (last_i < 1) begin
         last_i = 1;
      end else if (last_i > n_i) begin
         last_i = n_i;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      clr_cnt_in   = clr_cnt_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      row_req_in   = row_req_ff;
      col_req_in   = col_req_ff;
      last_req_in  = last_req_ff;
      value_in     = value_ff;
      inside_in    = inside_ff;
      result_in    = result_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      skip_in      = skip_ff;
      u_wr_en      = 1'b0;
      u_wr_addr    = acc_addr;
      u_wr_data    = value_ff;
      u_rd_addr    = acc_addr;
      b_wr_en      = 1'b0;
      ctrl         = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            u_wr_en    = 1'b1;
            u_wr_addr  = clr_cnt_ff;
            u_wr_data  = '0;
            clr_cnt_in = clr_cnt_ff + ONE_A;
            if (clr_cnt_ff == LAST_A) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_op;
               row_req_in  = req_row;
               col_req_in  = req_col;
               last_req_in = req_last_row;
               value_in    = req_value;
               state_in    = S_ACCESS;
            end
         end
         S_ACCESS: begin
            inside_in = acc_inside;
            result_in = '0;
            pend_in   = 1'b0;
            case (op_ff)
               OP_WRITE_U: begin
                  u_wr_en  = acc_inside;
                  state_in = S_DONE;
               end
               OP_WRITE_B: begin
                  b_wr_en  = acc_inside;
                  state_in = S_DONE;
               end
               OP_READ_U: begin
                  state_in = S_RDWAIT;
               end
               default: begin
                  ctrl.best_clr = 1'b1;
                  row_in   = IDX_W'(first_i);
                  col_in   = ONE_I;
                  n_in     = IDX_W'(n_i);
                  last_in  = IDX_W'(last_i);
                  k_in     = ADDR_W'(first_i * STRIDE + 1);
                  skip_in  = ADDR_W'(STRIDE - n_i + 1);
                  phase_in = PH_UP;
                  state_in = (first_i > last_i) ? S_DONE : S_SWEEP;
               end
            endcase
         end
         S_RDWAIT: begin
            result_in = inside_ff ? u_rdata : '0;
            state_in  = S_DONE;
         end
         S_SWEEP: begin
            phase_in = phase_ff + 3'd1;
            case (phase_ff)
               PH_UP: begin
                  u_rd_addr     = k_ff - STRIDE_A;
                  ctrl.best_upd = pend_ff;
                  pend_in       = 1'b0;
               end
               PH_DOWN: begin
                  u_rd_addr    = k_ff + STRIDE_A;
                  ctrl.acc_op  = ACC_LOAD;
                  ctrl.prod_en = 1'b1;
               end
               PH_LEFT: begin
                  u_rd_addr   = k_ff - ONE_A;
                  ctrl.acc_op = ACC_ADD_U;
               end
               PH_RIGHT: begin
                  u_rd_addr   = k_ff + ONE_A;
                  ctrl.acc_op = ACC_ADD_U;
               end
               PH_CENTER: begin
                  u_rd_addr   = k_ff;
                  ctrl.acc_op = ACC_ADD_U;
               end
               PH_PROD: begin
                  ctrl.old_en = 1'b1;
                  ctrl.acc_op = ACC_ADD_P;
               end
               default: begin
                  u_wr_en    = 1'b1;
                  u_wr_addr  = k_ff;
                  u_wr_data  = new_value;
                  ctrl.nv_en = 1'b1;
                  pend_in    = 1'b1;
                  phase_in   = PH_UP;
                  if (col_ff == n_ff) begin
                     if (row_ff == last_ff) begin
                        state_in = S_SFIN;
                     end else begin
                        row_in = row_ff + ONE_I;
                        col_in = ONE_I;
                        k_in   = k_ff + skip_ff;
                     end
                  end else begin
                     col_in = col_ff + ONE_I;
                     k_in   = k_ff + ONE_A;
                  end
               end
            endcase
         end
         S_SFIN: begin
            ctrl.best_upd = pend_ff;
            pend_in       = 1'b0;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (op_ff == OP_SWEEP) ? best_change : result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         phase_ff         <= PH_UP;
         clr_cnt_ff       <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         step_squared_ff  <= STEP_SQUARED_RESET;
         interior_size_ff <= INTERIOR_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_STEP_SQUARED) begin
               step_squared_ff <= csr_wdata;
            end
            if (csr_index == CSR_INTERIOR_SIZE) begin
               interior_size_ff <= csr_wdata[FIELD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      row_req_ff  <= row_req_in;
      col_req_ff  <= col_req_in;
      last_req_ff <= last_req_in;
      value_ff    <= value_in;
      inside_ff   <= inside_in;
      result_ff   <= result_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      n_ff        <= n_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      skip_ff     <= skip_in;
   end

   gsp_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CELLS)
   ) u_grid_u (
      .clock   (clock),
      .wr_en   (u_wr_en),
      .wr_addr (u_wr_addr),
      .wr_data (u_wr_data),
      .rd_addr (u_rd_addr),
      .rd_data (u_rdata)
   );

   gsp_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CELLS)
   ) u_grid_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (acc_addr),
      .wr_data (value_ff),
      .rd_addr (k_ff),
      .rd_data (b_rdata)
   );

   gsp_dpath u_dpath (
      .clock        (clock),
      .ctrl         (ctrl),
      .step_squared (step_squared_ff),
      .u_rdata      (u_rdata),
      .b_rdata      (b_rdata),
      .new_value    (new_value),
      .best_change  (best_change)
   );

   a_sweep_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (row_ff >= ONE_I) && (row_ff <= last_ff) &&
                                (col_ff >= ONE_I) && (col_ff <= n_ff))
      else $error("sweep position outside the clamped window");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (phase_ff <= PH_WRITE))
      else $error("sweep phase out of range");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (u_wr_en && !req_ready))
      else $error("request possible during the clearing pass");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response loaded outside the done state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_ACCESS))
      else $error("accepted request did not start");

endmodule

// ===== tb/gauss_seidel_poisson_sweep_core_tb.sv =====
module gauss_seidel_poisson_sweep_core_tb;
   import gsp_pkg::*;

   typedef struct {
      logic [1:0]               op;
      logic [FIELD_W-1:0]       row;
      logic [FIELD_W-1:0]       col;
      logic [FIELD_W-1:0]       last_row;
      logic signed [DATA_W-1:0] value;
   } grid_request_type;

   localparam longint Q28_MAX = 64'sd2147483647;
   localparam longint Q28_MIN = -64'sd2147483648;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_op = OP_READ_U;
   logic [FIELD_W-1:0]       req_row = '0;
   logic [FIELD_W-1:0]       req_col = '0;
   logic [FIELD_W-1:0]       req_last_row = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_STEP_SQUARED;
   logic [DATA_W-1:0]        csr_wdata = '0;

   logic signed [DATA_W-1:0] model_u [CELLS] = '{default: '0};
   logic signed [DATA_W-1:0] model_b [CELLS] = '{default: '0};
   logic [DATA_W-1:0]        model_step_sq = STEP_SQUARED_RESET;
   logic [FIELD_W-1:0]       model_size = INTERIOR_SIZE_RESET;
   logic signed [DATA_W-1:0] pending_data_q [$];
   int                       error_count = 0;
   int                       rsp_hold_cycles = 0;
   int                       req_calm = 0;
   int                       rsp_calm = 0;

   gauss_seidel_poisson_sweep_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_last_row (req_last_row),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_idle(inout int calm);
      if (calm == 0 && $urandom_range(0, 9) == 0)
         calm = $urandom_range(5, 25);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic grid_request_type pack_request(logic [1:0] op, int row, int col, int last,
                                                     logic signed [DATA_W-1:0] value);
      grid_request_type q;
      q.op = op;
      q.row = FIELD_W'(row);
      q.col = FIELD_W'(col);
      q.last_row = FIELD_W'(last);
      q.value = value;
      return q;
   endfunction

   function automatic int active_size();
      if (model_size < 2)
         return 2;
      if (model_size > GRID_N)
         return GRID_N;
      return model_size;
   endfunction

   function automatic logic signed [DATA_W-1:0] saturate_q28(longint v);
      if (v > Q28_MAX)
         return 32'sh7FFF_FFFF;
      if (v < Q28_MIN)
         return 32'sh8000_0000;
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] relax_rows(int first, int last);
      int n;
      int k;
      longint best;
      longint old_v;
      longint acc;
      longint prod;
      longint change;
      logic signed [DATA_W-1:0] next_v;
      n = active_size();
      first = (first < 1) ? 1 : (first > n) ? n : first;
      last = (last < 1) ? 1 : (last > n) ? n : last;
      best = 0;
      for (int r = first; r <= last; r++) begin
         for (int c = 1; c <= n; c++) begin
            k = r * STRIDE + c;
            old_v = model_u[k];
            prod = longint'(model_b[k]) * longint'({32'd0, model_step_sq});
            acc = longint'(model_u[k - STRIDE]) + longint'(model_u[k + STRIDE])
                + longint'(model_u[k - 1]) + longint'(model_u[k + 1]);
            acc += prod >>> 32;
            next_v = saturate_q28((acc + 2) >>> 2);
            model_u[k] = next_v;
            change = old_v - longint'(next_v);
            if (change < 0)
               change = -change;
            if (change > best)
               best = change;
         end
      end
      return saturate_q28(best);
   endfunction

   function automatic logic signed [DATA_W-1:0] apply_request(grid_request_type q);
      bit on_grid;
      int k;
      logic signed [DATA_W-1:0] data;
      on_grid = (q.row <= GRID_N + 1) && (q.col <= GRID_N + 1);
      k = int'(q.row) * STRIDE + int'(q.col);
      data = '0;
      case (q.op)
         OP_WRITE_U: begin
            if (on_grid)
               model_u[k] = q.value;
         end
         OP_WRITE_B: begin
            if (on_grid)
               model_b[k] = q.value;
         end
         OP_READ_U: begin
            if (on_grid)
               data = model_u[k];
         end
         default: begin
            data = relax_rows(q.row, q.last_row);
         end
      endcase
      return data;
   endfunction

   task automatic send_request(grid_request_type q);
      int gap;
      gap = pick_idle(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= q.op;
      req_row <= q.row;
      req_col <= q.col;
      req_last_row <= q.last_row;
      req_value <= q.value;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_data_q.push_back(apply_request(q));
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_data_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [DATA_W-1:0] data);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (index == CSR_STEP_SQUARED)
         model_step_sq = data;
      else
         model_size = data[FIELD_W-1:0];
   endtask

   task automatic load_rhs(int row_lo, int row_hi, int n);
      for (int r = row_lo; r <= row_hi; r++)
         for (int c = 1; c <= n; c++)
            send_request(pack_request(OP_WRITE_B, r, c, $urandom, $urandom));
   endtask

   task automatic seed_stencil(logic signed [DATA_W-1:0] center,
                               logic signed [DATA_W-1:0] around,
                               logic signed [DATA_W-1:0] rhs);
      send_request(pack_request(OP_WRITE_U, 1, 1, 0, center));
      send_request(pack_request(OP_WRITE_U, 0, 1, 0, around));
      send_request(pack_request(OP_WRITE_U, 2, 1, 0, around));
      send_request(pack_request(OP_WRITE_U, 1, 0, 0, around));
      send_request(pack_request(OP_WRITE_U, 1, 2, 0, around));
      send_request(pack_request(OP_WRITE_B, 1, 1, 0, rhs));
   endtask

   function automatic grid_request_type random_request();
      int n;
      int pick;
      logic [1:0] op;
      int row;
      int col;
      int last;
      logic signed [DATA_W-1:0] value;
      n = active_size();
      pick = $urandom_range(0, 9);
      op = (pick < 3) ? OP_WRITE_U : (pick < 4) ? OP_WRITE_B : (pick < 7) ? OP_READ_U : OP_SWEEP;
      row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n + 1);
      col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n + 1);
      last = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n + 1);
      if ($urandom_range(0, 1) == 0)
         value = $urandom;
      else
         value = $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
      return pack_request(op, row, col, last, value);
   endfunction

   task automatic test_cell_access();
      send_request(pack_request(OP_READ_U, 0, 0, 0, 0));
      send_request(pack_request(OP_READ_U, GRID_N + 1, GRID_N + 1, 0, 0));
      send_request(pack_request(OP_WRITE_U, GRID_N + 1, 0, 0, 32'sh7FFF_FFFF));
      send_request(pack_request(OP_WRITE_U, 0, GRID_N + 1, 0, 32'sh8000_0000));
      send_request(pack_request(OP_READ_U, GRID_N + 1, 0, 0, 0));
      send_request(pack_request(OP_READ_U, 0, GRID_N + 1, 0, 0));
      send_request(pack_request(OP_WRITE_U, GRID_N + 2, 5, 0, 32'sh1234_5678));
      send_request(pack_request(OP_READ_U, GRID_N + 2, 5, 0, 0));
      send_request(pack_request(OP_WRITE_U, 7, 255, 255, -1));
      send_request(pack_request(OP_READ_U, 255, 255, 255, 0));
      send_request(pack_request(OP_WRITE_B, 3, 200, 0, 32'sh7FFF_FFFF));
      send_request(pack_request(OP_WRITE_U, 64, 64, 0, 32'sh0000_0001));
      send_request(pack_request(OP_READ_U, 64, 64, 0, 0));
   endtask

   task automatic test_empty_sweep();
      send_request(pack_request(OP_SWEEP, 5, 0, 3, 0));
      send_request(pack_request(OP_SWEEP, 200, 255, 0, -1));
   endtask

   task automatic test_register_extremes();
      write_register(CSR_INTERIOR_SIZE, 32'd0);
      write_register(CSR_STEP_SQUARED, 32'hFFFF_FFFF);
      load_rhs(1, 2, 2);
      seed_stencil(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_request(pack_request(OP_SWEEP, 1, 0, 1, 0));
      send_request(pack_request(OP_READ_U, 1, 1, 0, 0));
      seed_stencil(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
      send_request(pack_request(OP_SWEEP, 1, 0, 1, 0));
      send_request(pack_request(OP_READ_U, 1, 2, 0, 0));
      write_register(CSR_STEP_SQUARED, 32'd0);
      send_request(pack_request(OP_SWEEP, 0, 0, 255, 0));
      write_register(CSR_INTERIOR_SIZE, 32'hFFFF_FF01);
      send_request(pack_request(OP_SWEEP, 2, 0, 9, 0));
      write_register(CSR_INTERIOR_SIZE, 32'd255);
      write_register(CSR_STEP_SQUARED, STEP_SQUARED_RESET);
      send_request(pack_request(OP_SWEEP, 200, 0, 100, 0));
   endtask

   task automatic test_random_traffic();
      int sizes [3];
      int n;
      logic [DATA_W-1:0] step;
      sizes = '{2, 3, 0};
      foreach (sizes[i]) begin
         n = (sizes[i] == 0) ? $urandom_range(3, 5) : sizes[i];
         case ($urandom_range(0, 4))
            0: step = '0;
            1: step = '1;
            2: step = STEP_SQUARED_RESET;
            default: step = $urandom;
         endcase
         write_register(CSR_STEP_SQUARED, step);
         write_register(CSR_INTERIOR_SIZE, ($urandom & 32'hFFFF_FF00) | n);
         load_rhs(1, n, n);
         repeat (8) send_request(random_request());
      end
   endtask

   task automatic test_response_backpressure();
      wait_for_idle();
      rsp_hold_cycles = 300;
      repeat (8) send_request(random_request());
   endtask

   initial begin : response_checker
      logic signed [DATA_W-1:0] want;
      int stall;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         stall = pick_idle(rsp_calm);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_data_q.size() == 0) begin
            $error("data: expected no response, actual %0d", rsp_data);
            error_count++;
         end else begin
            want = pending_data_q.pop_front();
            if (rsp_data !== want) begin
               $error("data: expected %0d, actual %0d", want, rsp_data);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_cell_access();
      test_empty_sweep();
      test_register_extremes();
      test_random_traffic();
      test_response_backpressure();
      wait_for_idle();
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_data_q.size() == 0)
         $display("gauss_seidel_poisson_sweep_core test passed");
      else
         $display("gauss_seidel_poisson_sweep_core test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("gauss_seidel_poisson_sweep_core test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/gsp_pkg.sv
rtl/core/gsp_ram.sv
rtl/core/gsp_dpath.sv
rtl/core/gauss_seidel_poisson_sweep_core.sv
tb/gauss_seidel_poisson_sweep_core_tb.sv
